### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tpl_pkg.sv
// ----------------------------------------------------------------------------
// Text pattern locator package
// Shared widths, codes and word types of the text pattern locator.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int PATTERN_MAX_DEF = 16;   // default window depth
  localparam int PAT_BYTES       = 16;   // pattern bytes held in the registers
  localparam int PAT_IDX_W       = 4;    // index into the pattern bytes
  localparam int LINE_W          = 20;
  localparam int COL_W           = 16;
  localparam int FOUND_W         = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 2;
  localparam int PAT_LEN_W       = 5;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN  = 2'd2;

  localparam logic RESULT_MATCH   = 1'b0;
  localparam logic RESULT_SUMMARY = 1'b1;

  typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic               result_kind;
    logic [LINE_W-1:0]  line_number;
    logic [COL_W-1:0]   start_column;
    logic [FOUND_W-1:0] match_total;
    logic               any_found;
  } out_word_t;

  // Control that every cell of the window sees in the same cycle.
  typedef struct packed {
    logic       shift;
    logic       clear;
    logic [7:0] data;
  } chain_ctrl_t;

  // Per-cell compare setup derived from the pattern registers.
  typedef struct packed {
    logic       en;
    logic [7:0] exp_byte;
  } cell_cfg_t;

endpackage

### rtl/core/text_pattern_locator_core.sv
// ----------------------------------------------------------------------------
// Text pattern locator core
// Finds every occurrence, overlaps included, of a pattern of up to
// PATTERN_MAX bytes in a byte stream, reports its line and start column, and sums up each text.
// ----------------------------------------------------------------------------
// Pipeline: the first stage holds a taken word, the output register its
// result word. One input word per cycle unless the output stalls with the
// first stage full; the chain shifts once per ordinary byte, compares in parallel.
// Reset: asynchronous, active low; clears the window, sets the line counter
// to one, the pattern length to one and the pattern bytes to zero.
// ----------------------------------------------------------------------------
module text_pattern_locator_core #(
  parameter int PATTERN_MAX = tpl_pkg::PATTERN_MAX_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [tpl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Text input channel.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  tpl_pkg::in_word_t                in_data_i,
  // Result output channel.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output tpl_pkg::out_word_t               out_data_o
);

  localparam int LenW = $clog2(PATTERN_MAX + 1);
  localparam int CmpW = (LenW > tpl_pkg::PAT_LEN_W) ? LenW : tpl_pkg::PAT_LEN_W;
  localparam int LW   = tpl_pkg::LINE_W;
  localparam int CW   = tpl_pkg::COL_W;
  localparam int FW   = tpl_pkg::FOUND_W;

  // Configuration registers.
  logic [tpl_pkg::CFG_DATA_W-1:0] pat_low_q, pat_high_q;
  logic [tpl_pkg::PAT_LEN_W-1:0]  pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= tpl_pkg::PAT_LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpl_pkg::CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        tpl_pkg::CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        tpl_pkg::CFG_PAT_LEN:  pat_len_q  <= cfg_data_i[tpl_pkg::PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The effective length is the programmed one clamped to 1..PATTERN_MAX.
  logic [CmpW-1:0] len_ext;
  logic [LenW-1:0] eff_len;

  always_comb begin
    len_ext = CmpW'(pat_len_q);
    if (len_ext == '0) begin
      eff_len = LenW'(1);
    end else if (len_ext > CmpW'(PATTERN_MAX)) begin
      eff_len = LenW'(PATTERN_MAX);
    end else begin
      eff_len = len_ext[LenW-1:0];
    end
  end

  // Handshake. The first stage holds the word whose window is now in the
  // chain; it moves on whenever the output register is free or being drained.
  logic in_acc, advance, s1_fire;
  logic is_eot, is_newline;

  logic          s1_valid_q, s1_valid_d;
  logic          s1_kind_q;
  logic [LW-1:0] s1_line_q;
  logic [CW-1:0] s1_col_q;

  logic          out_valid_q, out_valid_d;
  tpl_pkg::out_word_t out_q, out_d;

  assign advance    = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_eot     = in_data_i.end_of_text;
  assign is_newline = !is_eot && (in_data_i.text_byte == tpl_pkg::NEWLINE_BYTE);

  // Line and column counters, updated as each word is taken.
  logic [LW-1:0] line_q, line_d;
  logic [CW-1:0] col_q, col_d;

  always_comb begin
    line_d = line_q;
    col_d  = col_q;
    if (in_acc) begin
      if (is_eot) begin
        line_d = LW'(1);
        col_d  = '0;
      end else if (is_newline) begin
        if (line_q != '1) begin
          line_d = line_q + LW'(1);
        end
        col_d = '0;
      end else if (col_q != '1) begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= LW'(1);
      col_q  <= '0;
    end else begin
      line_q <= line_d;
      col_q  <= col_d;
    end
  end

  // The window: ordinary bytes shift in, newline and end of text empty it.
  tpl_pkg::chain_ctrl_t chain_ctrl;
  logic                 hit;

  assign chain_ctrl.shift = in_acc && !is_eot && !is_newline;
  assign chain_ctrl.clear = in_acc && (is_eot || is_newline);
  assign chain_ctrl.data  = in_data_i.text_byte;

  tpl_chain #(
    .PATTERN_MAX (PATTERN_MAX),
    .LenW        (LenW)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (chain_ctrl),
    .pattern_i ({pat_high_q, pat_low_q}),
    .eff_len_i (eff_len),
    .hit_o     (hit)
  );

  // A newline never yields a result, so it does not enter the first stage.
  always_comb begin
    if (in_acc && !is_newline) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !is_newline) begin
      s1_kind_q <= is_eot ? tpl_pkg::RESULT_SUMMARY : tpl_pkg::RESULT_MATCH;
      s1_line_q <= line_q;
      s1_col_q  <= col_q;
    end
  end

  // Second stage: the match decision, the match counter and the result word.
  // The start column backs up by length - 1 from the column of the newest
  // byte, floors at zero and stays pinned once the column has saturated.
  logic [FW-1:0] found_q, found_d, found_inc;
  logic [CW-1:0] back, start_col;

  assign found_inc = (found_q != '1) ? found_q + FW'(1) : found_q;
  assign back      = CW'(eff_len - LenW'(1));

  always_comb begin
    if (s1_col_q == '1) begin
      start_col = '1;
    end else if (s1_col_q >= back) begin
      start_col = s1_col_q - back;
    end else begin
      start_col = '0;
    end
  end

  always_comb begin
    found_d     = found_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_fire) begin
      if (s1_kind_q == tpl_pkg::RESULT_SUMMARY) begin
        out_d.result_kind  = tpl_pkg::RESULT_SUMMARY;
        out_d.line_number  = s1_line_q;
        out_d.start_column = '0;
        out_d.match_total  = found_q;
        out_d.any_found    = (found_q != '0);
        out_valid_d        = 1'b1;
        found_d            = '0;
      end else if (hit) begin
        out_d.result_kind  = tpl_pkg::RESULT_MATCH;
        out_d.line_number  = s1_line_q;
        out_d.start_column = start_col;
        out_d.match_total  = found_inc;
        out_d.any_found    = 1'b1;
        out_valid_d        = 1'b1;
        found_d            = found_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/tpl_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one text byte of the current line, passes it on at each shift and
// compares it with the pattern byte aligned to its position.
// ----------------------------------------------------------------------------
module tpl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpl_pkg::chain_ctrl_t ctrl_i,
  input  tpl_pkg::cell_cfg_t  cfg_i,
  input  logic [7:0]          prev_byte_i,
  input  logic                prev_valid_i,
  output logic [7:0]          byte_o,
  output logic                valid_o,
  output logic                ok_o
);

  logic [7:0] byte_q;
  logic       valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= prev_byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  // A cell beyond the pattern length always agrees.
  assign ok_o    = !cfg_i.en || (valid_q && (byte_q == cfg_i.exp_byte));

endmodule

### rtl/core/tpl_chain.sv
// ----------------------------------------------------------------------------
// Window chain
// Row of cells holding the newest bytes of the line, newest in cell 0, and
// the AND of their compares, which flags a match ending at the newest byte.
// ----------------------------------------------------------------------------
module tpl_chain #(
  parameter int PATTERN_MAX = tpl_pkg::PATTERN_MAX_DEF,
  parameter int LenW        = $clog2(PATTERN_MAX + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpl_pkg::chain_ctrl_t ctrl_i,
  input  tpl_pkg::pattern_t    pattern_i,
  input  logic [LenW-1:0]      eff_len_i,
  output logic                 hit_o
);

  localparam int CmpW = (LenW > tpl_pkg::PAT_LEN_W) ? LenW : tpl_pkg::PAT_LEN_W;

  logic [7:0]             cell_byte  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_valid;
  logic [PATTERN_MAX-1:0] cell_ok;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    tpl_pkg::cell_cfg_t cfg;
    logic [LenW-1:0]    idx;
    logic [CmpW-1:0]    idx_ext;
    logic [7:0]         prev_byte;
    logic               prev_valid;

    // Cell k lines up with pattern byte (length - 1 - k).
    always_comb begin
      idx          = eff_len_i - LenW'(1) - LenW'(k);
      idx_ext      = CmpW'(idx);
      cfg.en       = eff_len_i > LenW'(k);
      cfg.exp_byte = (idx_ext < CmpW'(tpl_pkg::PAT_BYTES)) ?
                     pattern_i[idx_ext[tpl_pkg::PAT_IDX_W-1:0]] : 8'h00;
    end

    if (k == 0) begin : g_head
      assign prev_byte  = ctrl_i.data;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_byte  = cell_byte[k-1];
      assign prev_valid = cell_valid[k-1];
    end

    tpl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .cfg_i        (cfg),
      .prev_byte_i  (prev_byte),
      .prev_valid_i (prev_valid),
      .byte_o       (cell_byte[k]),
      .valid_o      (cell_valid[k]),
      .ok_o         (cell_ok[k])
    );
  end

  assign hit_o = &cell_ok;

endmodule

### rtl/core/tpl_checker.sv
// ----------------------------------------------------------------------------
// Text pattern locator checker
// Port-level assertions on the result words of the locator core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tpl_pkg::out_word_t out_data_o
);

  // A stalled result word stays put.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // A summary carries a zero column and a found flag that tracks the count.
  `ASSERT_IMPLIES(a_sum_column, clk_i, rst_ni, out_valid_o && (out_data_o.result_kind == tpl_pkg::RESULT_SUMMARY), (out_data_o.start_column == '0) && (out_data_o.any_found == (out_data_o.match_total != '0)), "summary word inconsistent")

  // A match report always counts itself.
  `ASSERT_IMPLIES(a_match_count, clk_i, rst_ni, out_valid_o && (out_data_o.result_kind == tpl_pkg::RESULT_MATCH), out_data_o.any_found && (out_data_o.match_total != '0), "match report with zero count")

  // Lines are numbered from one.
  `ASSERT_IMPLIES(a_line_nonzero, clk_i, rst_ni, out_valid_o, out_data_o.line_number != '0, "line number of zero")

endmodule

bind text_pattern_locator_core tpl_checker u_tpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text pattern locator testbench
// Streams text words into the core under random valid/ready pressure. A
// scoreboard class predicts every match report and end-of-text summary from
// the accepted words and compares each result word field by field. The run
// covers directed corner cases and random texts over many pattern settings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          WIN          = tpl_pkg::PATTERN_MAX_DEF;
  localparam int          PAT_LEN_W    = tpl_pkg::PAT_LEN_W;
  localparam int          CFG_IDX_W    = tpl_pkg::CFG_IDX_W;
  localparam int          CFG_DATA_W   = tpl_pkg::CFG_DATA_W;
  localparam int          COL_W        = tpl_pkg::COL_W;
  localparam int          LINE_W       = tpl_pkg::LINE_W;
  localparam int          FOUND_W      = tpl_pkg::FOUND_W;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned RANDOM_WORDS = 1200;
  // Margin after the last predicted result word arrives; leave extra margin.
  localparam int unsigned DRAIN_CYCLES = 8;

  // Scoreboard: keeps its own copy of the pattern registers and the line
  // state, predicts the result words of each accepted text word and checks
  // the result words in order.
  class match_scoreboard;
    tpl_pkg::pattern_t      pat_bytes;
    logic [PAT_LEN_W-1:0]   pat_len;
    logic [7:0]             window [WIN];
    int unsigned            fill;
    logic [COL_W-1:0]       column;
    logic [LINE_W-1:0]      line_no;
    logic [FOUND_W-1:0]     found;
    tpl_pkg::out_word_t     expected_q [$];
    int unsigned            errors;

    function new();
      pat_bytes = '0;
      pat_len   = 5'd1;
      line_no   = 1;
      found     = 0;
      errors    = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (window[i]) window[i] = 8'h00;
      fill   = 0;
      column = 0;
    endfunction

    // A length of zero acts as one, anything beyond the window as the window.
    function int unsigned eff_len(logic [PAT_LEN_W-1:0] n);
      if (n == 0) return 1;
      if (n > WIN) return WIN;
      return 32'(n);
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        tpl_pkg::CFG_PAT_LOW:  pat_bytes[7:0]  = data;
        tpl_pkg::CFG_PAT_HIGH: pat_bytes[15:8] = data;
        tpl_pkg::CFG_PAT_LEN:  pat_len         = data[PAT_LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_text_word(tpl_pkg::in_word_t w);
      tpl_pkg::out_word_t res;
      int unsigned        len;
      logic [COL_W-1:0]   col;
      logic [COL_W-1:0]   back;
      bit                 hit;
      if (w.end_of_text) begin
        res.result_kind  = tpl_pkg::RESULT_SUMMARY;
        res.line_number  = line_no;
        res.start_column = 0;
        res.match_total  = found;
        res.any_found    = (found != 0);
        expected_q.push_back(res);
        clear_line();
        line_no = 1;
        found   = 0;
        return;
      end
      if (w.text_byte == tpl_pkg::NEWLINE_BYTE) begin
        if (line_no != '1) line_no++;
        clear_line();
        return;
      end
      for (int i = WIN - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = w.text_byte;
      if (fill < WIN) fill++;
      col = column;
      if (column != '1) column++;
      len = eff_len(pat_len);
      back = COL_W'(len - 1);
      hit = (fill >= len);
      for (int i = 0; i < len; i++)
        if (window[len-1-i] != pat_bytes[i]) hit = 0;
      if (!hit) return;
      if (found != '1) found++;
      res.result_kind  = tpl_pkg::RESULT_MATCH;
      res.line_number  = line_no;
      if (col == '1) res.start_column = '1;
      else res.start_column = (col >= back) ? col - back : '0;
      res.match_total  = found;
      res.any_found    = 1'b1;
      expected_q.push_back(res);
    endfunction

    function void compare_field(string field_name, longint unsigned want,
                                longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name, want, got);
        errors++;
      end
    endfunction

    function void check_result_word(tpl_pkg::out_word_t got);
      tpl_pkg::out_word_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
      compare_field("line_number", 64'(want.line_number), 64'(got.line_number));
      compare_field("start_column", 64'(want.start_column), 64'(got.start_column));
      compare_field("match_total", 64'(want.match_total), 64'(got.match_total));
      compare_field("any_found", 64'(want.any_found), 64'(got.any_found));
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = tpl_pkg::CFG_PAT_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  tpl_pkg::in_word_t     in_data  = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tpl_pkg::out_word_t    out_data;

  // Chance in a hundred that the sender or the receiver idles in a cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycle_count   = 0;

  match_scoreboard sb = new();

  text_pattern_locator_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  // The receiver drops ready at random; at zero percent it stays ready.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted text word goes to the predictor at the edge it is taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_text_word(in_data);
  end

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result_word(out_data);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic tpl_pkg::in_word_t make_word(logic [7:0] b, logic eot);
    tpl_pkg::in_word_t w;
    w.text_byte   = b;
    w.end_of_text = eot;
    return w;
  endfunction

  // Offers one word, with random idle cycles first, and returns at the edge
  // where it is taken. Valid stays high if the next word follows at once.
  task automatic send_word(tpl_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Writes all three registers on back-to-back cycles; the core is idle.
  task automatic write_registers(logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high,
                                 logic [CFG_DATA_W-1:0] len);
    cfg_we   <= 1'b1;
    cfg_idx  <= tpl_pkg::CFG_PAT_LOW;
    cfg_data <= low;
    sb.write_register(tpl_pkg::CFG_PAT_LOW, low);
    @(posedge clk);
    cfg_idx  <= tpl_pkg::CFG_PAT_HIGH;
    cfg_data <= high;
    sb.write_register(tpl_pkg::CFG_PAT_HIGH, high);
    @(posedge clk);
    cfg_idx  <= tpl_pkg::CFG_PAT_LEN;
    cfg_data <= len;
    sb.write_register(tpl_pkg::CFG_PAT_LEN, len);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every predicted result word has arrived, then lets the
  // pipeline run empty. The first edge lets the input monitor catch up.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random text under one random pattern setting. Most bytes come from
  // a small alphabet, and whole copies of the pattern are dropped in so that
  // long patterns match too; newlines, full-range bytes and end-of-text
  // words break the lines and texts up.
  task automatic run_random_phase(int unsigned n_words);
    logic [7:0]            pat [16];
    logic [7:0]            base;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
    logic [CFG_DATA_W-1:0] len_data;
    logic [PAT_LEN_W-1:0]  raw_len;
    int unsigned           eff;
    int unsigned           span;
    int unsigned           sent;
    int unsigned           pick;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: raw_len = PAT_LEN_W'($urandom_range(4, 1));
      6, 7:             raw_len = PAT_LEN_W'($urandom_range(16, 5));
      8:                raw_len = 0;
      default:          raw_len = PAT_LEN_W'($urandom_range(31, 17));
    endcase
    eff  = sb.eff_len(raw_len);
    base = 8'($urandom_range(255));
    span = $urandom_range(2, 1);
    for (int i = 0; i < 16; i++) pat[i] = 8'($urandom_range(255));
    for (int i = 0; i < eff; i++) pat[i] = 8'(base + $urandom_range(span));
    if ($urandom_range(7) == 0) pat[$urandom_range(eff - 1)] = tpl_pkg::NEWLINE_BYTE;
    for (int i = 0; i < 8; i++) begin
      low[8*i +: 8]  = pat[i];
      high[8*i +: 8] = pat[i+8];
    end
    len_data = {$urandom, $urandom};
    len_data[PAT_LEN_W-1:0] = raw_len;
    write_registers(low, high, len_data);
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_word(make_word(8'($urandom_range(255)), 1'b1));
        sent++;
      end else if (pick < 12) begin
        send_word(make_word(tpl_pkg::NEWLINE_BYTE, 1'b0));
        sent++;
      end else if (pick < 20) begin
        send_word(make_word(8'($urandom_range(255)), 1'b0));
        sent++;
      end else if (pick < 35) begin
        for (int i = 0; i < eff; i++) send_word(make_word(pat[i], 1'b0));
        sent += eff;
      end else begin
        send_word(make_word(8'(base + $urandom_range(span)), 1'b0));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    int unsigned random_sent;
    int unsigned chunk;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Out of reset the pattern is one zero byte, so a zero
    // text byte must match with no register written.
    send_idle_pct = 25;
    recv_idle_pct = 68;
    send_word(make_word(8'h00, 1'b0));
    send_word(make_word(8'hFF, 1'b0));
    send_word(make_word(8'h00, 1'b0));
    send_word(make_word(8'hFF, 1'b1));
    wait_idle();

    // A length of zero behaves as a length of one; the newline moves the
    // second match to line two, column zero.
    write_registers(64'h61, 64'h0, 64'h0);
    send_word(make_word(8'h61, 1'b0));
    send_word(make_word(tpl_pkg::NEWLINE_BYTE, 1'b0));
    send_word(make_word(8'h61, 1'b0));
    send_word(make_word(8'h00, 1'b1));
    wait_idle();

    // A length beyond the window acts as the full window of all-ones bytes.
    write_registers('1, '1, 64'h1F);
    for (int i = 0; i < WIN; i++) send_word(make_word(8'hFF, 1'b0));
    send_word(make_word(8'h00, 1'b1));
    wait_idle();

    // Random part: one third under each idling mix.
    random_sent = 0;
    while (random_sent < RANDOM_WORDS) begin
      case (random_sent * 3 / RANDOM_WORDS)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      chunk = $urandom_range(90, 30);
      run_random_phase(chunk);
      random_sent += chunk;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
